@@ rtl/vdt_pkg.sv @@
// Shared types, constants and helpers for the vertex deduplication table.
package vdt_pkg;

  localparam int COORD_W = 32;
  localparam int DIFF_W  = 33;
  localparam int TOL_W   = 31;
  localparam int INDEX_W = 10;

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd1;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_CLEAR = 1'b1
  } command_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic issue;
    logic flush;
    logic finish_hit;
    logic finish_miss;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic issue_done;
    logic pipe_empty;
  } status_t;

  function automatic logic axis_close(input logic signed [DIFF_W-1:0] d,
                                      input logic [TOL_W-1:0] tol);
    logic signed [DIFF_W-1:0] t;
    t = signed'({2'b00, tol});
    return (d < t) && (d > -t);
  endfunction

endpackage

@@ rtl/vdt_ctrl.sv @@
// Controller state machine that sequences the table scan, append and clear.
module vdt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             command,
  input  vdt_pkg::status_t status,
  output logic             busy,
  output vdt_pkg::cmd_t    cmd
);

  vdt_pkg::state_t state;
  vdt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vdt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vdt_pkg::ST_IDLE: begin
        if (start && (command == vdt_pkg::CMD_ADD)) begin
          state_next = vdt_pkg::ST_SCAN;
        end
      end
      vdt_pkg::ST_SCAN: begin
        if (status.hit || (status.issue_done && status.pipe_empty)) begin
          state_next = vdt_pkg::ST_IDLE;
        end
      end
      default: state_next = vdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state)
      vdt_pkg::ST_IDLE: begin
        if (start) begin
          if (command == vdt_pkg::CMD_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      vdt_pkg::ST_SCAN: begin
        busy = 1'b1;
        if (status.hit) begin
          cmd.finish_hit = 1'b1;
          cmd.flush      = 1'b1;
        end else if (status.issue_done && status.pipe_empty) begin
          cmd.finish_miss = 1'b1;
        end else begin
          cmd.issue = !status.issue_done;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/vdt_datapath.sv @@
// Datapath with the vertex memory, the pipelined compare and the result registers.
module vdt_datapath #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_en,
  input  logic [vdt_pkg::TOL_W-1:0]             cfg_write_data,
  input  logic signed [vdt_pkg::COORD_W-1:0]    x_coord,
  input  logic signed [vdt_pkg::COORD_W-1:0]    y_coord,
  input  logic signed [vdt_pkg::COORD_W-1:0]    z_coord,
  input  vdt_pkg::cmd_t                         cmd,
  output vdt_pkg::status_t                      status,
  output logic                                  result_valid,
  output logic [vdt_pkg::INDEX_W-1:0]           vertex_index,
  output logic                                  is_new,
  output logic                                  table_overflow
);

  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam int CRD = vdt_pkg::COORD_W;
  localparam int DW  = vdt_pkg::DIFF_W;

  logic [3*CRD-1:0]              mem [MAX_VERTICES];
  logic [3*CRD-1:0]              rd_data;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 scan_addr;
  logic [vdt_pkg::TOL_W-1:0]     tolerance;
  logic [CRD-1:0]                px;
  logic [CRD-1:0]                py;
  logic [CRD-1:0]                pz;
  logic                          s1_valid;
  logic [AW-1:0]                 s1_idx;
  logic                          s2_valid;
  logic [AW-1:0]                 s2_idx;
  logic signed [DW-1:0]          dx;
  logic signed [DW-1:0]          dy;
  logic signed [DW-1:0]          dz;
  logic [CRD-1:0]                rd_x;
  logic [CRD-1:0]                rd_y;
  logic [CRD-1:0]                rd_z;
  logic                          full;

  assign full = (count == CW'(MAX_VERTICES));
  assign rd_x = rd_data[3*CRD-1:2*CRD];
  assign rd_y = rd_data[2*CRD-1:CRD];
  assign rd_z = rd_data[CRD-1:0];

  assign status.issue_done = (scan_addr == count);
  assign status.pipe_empty = !s1_valid && !s2_valid;
  assign status.hit = s2_valid
                      && vdt_pkg::axis_close(dx, tolerance)
                      && vdt_pkg::axis_close(dy, tolerance)
                      && vdt_pkg::axis_close(dz, tolerance);

  always_ff @(posedge clk) begin
    rd_data <= mem[scan_addr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_miss && !full) begin
      mem[count[AW-1:0]] <= {px, py, pz};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= vdt_pkg::TOL_RESET;
    end else if (cfg_write_en) begin
      tolerance <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.finish_miss && !full) begin
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
    end else if (cmd.load) begin
      scan_addr <= '0;
    end else if (cmd.issue) begin
      scan_addr <= scan_addr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px <= x_coord;
      py <= y_coord;
      pz <= z_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue && !cmd.flush;
      s2_valid <= s1_valid && !cmd.flush;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= scan_addr[AW-1:0];
    s2_idx <= s1_idx;
    dx     <= {rd_x[CRD-1], rd_x} - {px[CRD-1], px};
    dy     <= {rd_y[CRD-1], rd_y} - {py[CRD-1], py};
    dz     <= {rd_z[CRD-1], rd_z} - {pz[CRD-1], pz};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.clear || cmd.finish_hit || cmd.finish_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      vertex_index   <= '0;
      is_new         <= 1'b0;
      table_overflow <= 1'b0;
    end else if (cmd.finish_hit) begin
      vertex_index   <= vdt_pkg::INDEX_W'(s2_idx);
      is_new         <= 1'b0;
      table_overflow <= 1'b0;
    end else if (cmd.finish_miss) begin
      if (full) begin
        vertex_index   <= '0;
        is_new         <= 1'b0;
        table_overflow <= 1'b1;
      end else begin
        vertex_index   <= vdt_pkg::INDEX_W'(count);
        is_new         <= 1'b1;
        table_overflow <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/vertex_dedup_table.sv @@
// Top level of the vertex deduplication table: controller, datapath and checks.
//
// A request is taken when start is high and busy is low. The result of a
// clear request appears on the next cycle with busy staying low. An add
// request scans the stored vertices one entry per cycle through the single
// read port of the vertex memory and a compare pipeline, and holds busy
// until a match is found or every stored vertex has been compared. A match
// ends the scan early at the lowest matching index. Each result is shown
// for one cycle with result_valid high, and the receiver must take it then.
module vertex_dedup_table #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                command,
  input  logic signed [vdt_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [vdt_pkg::COORD_W-1:0]  y_coord,
  input  logic signed [vdt_pkg::COORD_W-1:0]  z_coord,
  input  logic                                cfg_write_en,
  input  logic [vdt_pkg::TOL_W-1:0]           cfg_write_data,
  output logic                                result_valid,
  output logic [vdt_pkg::INDEX_W-1:0]         vertex_index,
  output logic                                is_new,
  output logic                                table_overflow
);

  vdt_pkg::cmd_t    cmd;
  vdt_pkg::status_t status;

  vdt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  vdt_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .x_coord        (x_coord),
    .y_coord        (y_coord),
    .z_coord        (z_coord),
    .cmd            (cmd),
    .status         (status),
    .result_valid   (result_valid),
    .vertex_index   (vertex_index),
    .is_new         (is_new),
    .table_overflow (table_overflow)
  );

`ifndef SYNTHESIS
  a_new_or_overflow : assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(is_new && table_overflow))
    else $error("result marked both new and overflow");

  a_scan_ends_with_result : assert property (@(posedge clk) disable iff (rst)
    (!busy && $past(busy)) |-> result_valid)
    else $error("scan finished without a result");

  a_add_starts_scan : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == vdt_pkg::CMD_ADD)) |=> busy)
    else $error("add request did not start a scan");
`endif

endmodule
